@@ hw/rtl/urasc_pkg.sv @@
// shared types, constants and helpers for the unsigned to radix ascii converter
// no dependencies; imported by every other file of the block

package urasc_pkg;

	// payload widths
	localparam int VALUE_W = 64;
	localparam int RADIX_W = 5;
	localparam int CHAR_W  = 7;
	localparam int COUNT_W = 7;
	localparam int DIGIT_W = 4;

	// digit store
	localparam int MAX_DIGITS = 64;
	localparam int PTR_W      = $clog2(MAX_DIGITS);

	// divider: quotient bits resolved per cycle and cycles per division
	localparam int DIV_BITS   = 8;
	localparam int DIV_STEPS  = VALUE_W / DIV_BITS;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	// ascii offsets
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(8'h57);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DSTORE,
		ST_READ,
		ST_SHOW
	} urasc_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic shift_store;
		logic div_init;
		logic div_step;
		logic div_store;
		logic final_store;
		logic mem_read;
		logic ptr_dec;
	} urasc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic ge;
		logic pow2;
		logic div_last;
		logic ptr_zero;
	} urasc_sts_t;

	// radix below two reads as two, above sixteen as sixteen
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	// digit value to lowercase ascii
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_LETTER + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/urasc_if.sv @@
// valid/ready channel interfaces for the converter's input and output words
// depends on urasc_pkg for the payload widths

interface urasc_in_if
	import urasc_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [RADIX_W-1:0] radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

interface urasc_out_if
	import urasc_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  digit_char;
	logic               is_last;
	logic [COUNT_W-1:0] digit_count;

	modport source (output valid, output digit_char, output is_last, output digit_count,
		input ready);
	modport sink   (input valid, input digit_char, input is_last, input digit_count,
		output ready);
endinterface

@@ hw/rtl/urasc_ctrl.sv @@
// controller state machine: sequences division, digit storage and readout
// depends on urasc_pkg for the state enum and command/status structs

module urasc_ctrl
	import urasc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	input  urasc_sts_t sts,
	output urasc_cmd_t cmd,
	output logic       in_ready,
	output logic       out_valid
);

	urasc_state_t state_q;
	urasc_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.ge) begin
					state_d = ST_READ;
				end else if (!sts.pow2) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_DSTORE;
				end
			end
			ST_DSTORE: begin
				state_d = ST_CHECK;
			end
			ST_READ: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready) begin
					state_d = sts.ptr_zero ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK: begin
				if (!sts.ge) begin
					cmd.final_store = 1'b1;
				end else if (sts.pow2) begin
					cmd.shift_store = 1'b1;
				end else begin
					cmd.div_init = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_DSTORE: begin
				cmd.div_store = 1'b1;
			end
			ST_READ: begin
				cmd.mem_read = 1'b1;
			end
			ST_SHOW: begin
				out_valid   = 1'b1;
				cmd.ptr_dec = out_ready && !sts.ptr_zero;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/urasc_dp.sv @@
// datapath: value register, shared radix divider, digit store and output word
// depends on urasc_pkg for widths, command/status structs and digit helpers

module urasc_dp
	import urasc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  urasc_cmd_t         cmd,
	output urasc_sts_t         sts,
	input  logic [VALUE_W-1:0] value,
	input  logic [RADIX_W-1:0] radix,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               is_last,
	output logic [COUNT_W-1:0] digit_count
);

	logic [VALUE_W-1:0] val_q;
	logic [RADIX_W-1:0] rad_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [DIGIT_W-1:0] rd_q;
	logic [DIGIT_W-1:0] mem [MAX_DIGITS];

	logic [RADIX_W-1:0] rad_m1;
	logic [2:0]         shamt;
	logic [VALUE_W-1:0] val_shr;
	logic [VALUE_W-1:0] div_val;
	logic [DIGIT_W-1:0] div_rem;
	logic [RADIX_W-1:0] div_part;
	logic               wr_en;
	logic [DIGIT_W-1:0] wr_digit;

	// radix decode: power of two test and shift amount
	assign rad_m1 = rad_q - RADIX_W'(1);

	always_comb begin
		case (rad_q)
			RADIX_W'(2): shamt = 3'd1;
			RADIX_W'(4): shamt = 3'd2;
			RADIX_W'(8): shamt = 3'd3;
			default:     shamt = 3'd4;
		endcase
	end

	assign val_shr = val_q >> shamt;

	// restoring division, DIV_BITS quotient bits per cycle, quotient shifts into val
	always_comb begin
		div_rem  = rem_q;
		div_val  = val_q;
		div_part = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			div_part = {div_rem, div_val[VALUE_W-1]};
			div_val  = {div_val[VALUE_W-2:0], 1'b0};
			if (div_part >= rad_q) begin
				div_part   = div_part - rad_q;
				div_val[0] = 1'b1;
			end
			div_rem = div_part[DIGIT_W-1:0];
		end
	end

	// status to the controller
	assign sts.ge       = val_q >= VALUE_W'(rad_q);
	assign sts.pow2     = (rad_q & rad_m1) == '0;
	assign sts.div_last = step_q == STEP_W'(DIV_STEPS - 1);
	assign sts.ptr_zero = ptr_q == '0;

	// value, radix and remainder
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
			rad_q <= clamp_radix(radix);
		end else if (cmd.shift_store) begin
			val_q <= val_shr;
		end else if (cmd.div_step) begin
			val_q <= div_val;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_rem;
		end
	end

	// division step counter, digit count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q  <= '0;
			ptr_q  <= '0;
		end else begin
			if (cmd.div_init) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (wr_en) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
			if (cmd.final_store) begin
				ptr_q <= cnt_q[PTR_W-1:0];
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - PTR_W'(1);
			end
		end
	end

	// digit store, least significant digit at address zero
	assign wr_en = cmd.shift_store | cmd.div_store | cmd.final_store;

	always_comb begin
		if (cmd.shift_store) begin
			wr_digit = val_q[DIGIT_W-1:0] & rad_m1[DIGIT_W-1:0];
		end else if (cmd.div_store) begin
			wr_digit = rem_q;
		end else begin
			wr_digit = val_q[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[PTR_W-1:0]] <= wr_digit;
		end
		if (cmd.mem_read) begin
			rd_q <= mem[ptr_q];
		end
	end

	// output word
	assign digit_char  = digit_ascii(rd_q);
	assign is_last     = sts.ptr_zero;
	assign digit_count = cnt_q;

endmodule

@@ hw/rtl/unsigned_to_radix_ascii.sv @@
// Converts one 64-bit unsigned value per input word into its ASCII digits in radix 2..16
// (radix below 2 reads as 2, above 16 as 16), most significant digit first with no leading
// zeros, 'a'..'f' for digits above 9; zero gives "0". Every output word carries one digit,
// the total digit count and a flag on the final digit. One value is handled at a time: the
// input is ready only when the previous value's last digit has been taken. For a
// power-of-two radix each digit is shifted out of the value register; any other radix runs a
// shared restoring divider at 8 quotient bits per cycle to give every digit but the leading one.
// Readout goes through the registered digit store: each digit is read into a register and
// then shown, and an output stall holds it until it is taken.
// depends on urasc_pkg, urasc_if, urasc_ctrl and urasc_dp

module unsigned_to_radix_ascii
	import urasc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	urasc_in_if.sink    num,
	urasc_out_if.source chars
);

	urasc_cmd_t cmd;
	urasc_sts_t sts;

	// controller
	urasc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (num.valid),
		.out_ready (chars.ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (num.ready),
		.out_valid (chars.valid)
	);

	// datapath
	urasc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (num.value),
		.radix       (num.radix),
		.digit_char  (chars.digit_char),
		.is_last     (chars.is_last),
		.digit_count (chars.digit_count)
	);

endmodule
